/* hdl/gbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the go-back-n sender window block.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int CNT_W        = 8;
    localparam int SEQ_W        = 7;
    localparam int REQ_W        = 2;
    localparam int KIND_W       = 2;
    localparam int CFG_W        = 5;
    localparam int RESULT_LIMIT = 16;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);
    localparam int LIM_W        = CNT_W + 1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(4);

    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW    = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_DONE   = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND,
        ST_RESEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_msg;
        logic apply_ack;
        logic run_init;
        logic emit_new;
        logic emit_resend;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] ev_type;
        logic             count_zero;
        logic             active;
        logic             ack_ok;
        logic             ack_final;
        logic             can_send;
        logic             send_last;
        logic             can_resend;
        logic             resend_last;
        logic             slot_free;
    } sts_t;

endpackage
`default_nettype wire

/* hdl/gbn_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_req_if
// Event channel: one beat carries one sender event.
// ----------------------------------------------------------------------------
interface gbn_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] frame_total;
    logic [6:0] ack_seq;
    logic       is_ack;

    modport source (output valid, output req_type, output frame_total,
                    output ack_seq, output is_ack, input ready);
    modport sink   (input valid, input req_type, input frame_total,
                    input ack_seq, input is_ack, output ready);
endinterface
`default_nettype wire

/* hdl/gbn_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_res_if
// Result channel: one beat carries one frame command or a completion.
// ----------------------------------------------------------------------------
interface gbn_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [6:0] frame_seq;
    logic       last_of_run;

    modport source (output valid, output result_kind, output frame_seq,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input frame_seq,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

/* hdl/gbn_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_cfg_if
// Configuration write channel for the window size register.
// ----------------------------------------------------------------------------
interface gbn_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] win_size;

    modport source (output valid, output win_size, input ready);
    modport sink   (input valid, input win_size, output ready);
endinterface
`default_nettype wire

/* hdl/gbn_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_ctrl
// Controller: sequences event decode and the emission of result beats.
// ----------------------------------------------------------------------------
module gbn_ctrl
    import gbn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (sts.ev_type)
                    REQ_START:
                    begin
                        state_next = sts.count_zero ? ST_DONE : ST_SEND;
                    end
                    REQ_ACK:
                    begin
                        if (!sts.ack_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = sts.ack_final ? ST_DONE : ST_SEND;
                        end
                    end
                    REQ_TIMEOUT:
                    begin
                        state_next = sts.active ? ST_RESEND : ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SEND:
            begin
                if (!sts.can_send)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.slot_free && sts.send_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESEND:
            begin
                if (!sts.can_resend)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.slot_free && sts.resend_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (sts.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.run_init  = 1'b1;
                cmd.load_msg  = (sts.ev_type == REQ_START);
                cmd.apply_ack = (sts.ev_type == REQ_ACK) && sts.ack_ok;
            end
            ST_SEND:
            begin
                cmd.emit_new = sts.can_send && sts.slot_free;
            end
            ST_RESEND:
            begin
                cmd.emit_resend = sts.can_resend && sts.slot_free;
            end
            ST_DONE:
            begin
                cmd.emit_done = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/gbn_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_datapath
// Window state, event capture, window size register and result register.
// ----------------------------------------------------------------------------
module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW      = 16,
    parameter int MAX_FRAME_COUNT = 128
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [CNT_W-1:0]  frame_total,
    input  wire logic [SEQ_W-1:0]  ack_seq,
    input  wire logic              is_ack,
    input  wire logic              cfg_write,
    input  wire logic [CFG_W-1:0]  cfg_window,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [KIND_W-1:0]      out_kind,
    output logic [SEQ_W-1:0]       out_seq,
    output logic                   out_last
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0]     window_reg;
    logic [CFG_W-1:0]     window_next;
    logic [REQ_W-1:0]     ev_type_reg;
    logic [CNT_W-1:0]     ev_count_reg;
    logic [SEQ_W-1:0]     ev_ack_reg;
    logic                 ev_flag_reg;
    logic [CNT_W-1:0]     base_reg;
    logic [CNT_W-1:0]     base_next;
    logic [CNT_W-1:0]     send_reg;
    logic [CNT_W-1:0]     send_next;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     total_next;
    logic                 active_reg;
    logic                 active_next;
    logic [CNT_W-1:0]     cursor_reg;
    logic [CNT_W-1:0]     cursor_next;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [KIND_W-1:0]    kind_next;
    logic [SEQ_W-1:0]     seq_reg;
    logic [SEQ_W-1:0]     seq_next;
    logic                 last_reg;
    logic                 last_next;

    logic [WIN_W-1:0]     win_eff;
    logic [CNT_W-1:0]     count_sat;
    logic [LIM_W-1:0]     win_limit;
    logic [LIM_W-1:0]     send_inc;
    logic [LIM_W-1:0]     cursor_inc;
    logic [LIM_W-1:0]     ack_inc;
    logic [LIM_W-1:0]     total_ext;
    logic [LIM_W-1:0]     send_ext;
    logic [CNT_W-1:0]     ack_ext;
    logic                 below_limit;
    logic                 at_limit;

    // effective window, clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (32'(window_reg) > MAX_WINDOW)
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WIN_W'(window_reg);
        end
    end

    assign count_sat   = (32'(ev_count_reg) > MAX_FRAME_COUNT) ?
                         CNT_W'(MAX_FRAME_COUNT) : ev_count_reg;
    assign win_limit   = {1'b0, base_reg} + LIM_W'(win_eff);
    assign send_ext    = {1'b0, send_reg};
    assign total_ext   = {1'b0, total_reg};
    assign send_inc    = send_ext + LIM_W'(1);
    assign cursor_inc  = {1'b0, cursor_reg} + LIM_W'(1);
    assign ack_ext     = {1'b0, ev_ack_reg};
    assign ack_inc     = LIM_W'(ev_ack_reg) + LIM_W'(1);
    assign below_limit = (count_reg < RES_CNT_W'(RESULT_LIMIT));
    assign at_limit    = ((count_reg + RES_CNT_W'(1)) >= RES_CNT_W'(RESULT_LIMIT));

    always_comb
    begin
        sts.ev_type     = ev_type_reg;
        sts.count_zero  = (ev_count_reg == '0);
        sts.active      = active_reg;
        sts.ack_ok      = active_reg && ev_flag_reg &&
                          (ack_ext >= base_reg) && (ack_ext < send_reg);
        sts.ack_final   = (ack_inc >= total_ext);
        sts.can_send    = (send_reg < total_reg) && (send_ext < win_limit) && below_limit;
        sts.send_last   = (send_inc >= total_ext) || (send_inc >= win_limit) || at_limit;
        sts.can_resend  = (cursor_reg < send_reg) && below_limit;
        sts.resend_last = (cursor_inc >= send_ext) || at_limit;
        sts.slot_free   = !valid_reg || out_ready;
    end

    always_comb
    begin
        window_next = cfg_write ? cfg_window : window_reg;
        base_next   = base_reg;
        send_next   = send_reg;
        total_next  = total_reg;
        active_next = active_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        valid_next  = valid_reg && !out_ready;
        kind_next   = kind_reg;
        seq_next    = seq_reg;
        last_next   = last_reg;

        if (cmd.load_msg)
        begin
            total_next  = count_sat;
            base_next   = '0;
            send_next   = '0;
            active_next = (count_sat != '0);
        end
        if (cmd.apply_ack)
        begin
            base_next   = CNT_W'(ack_inc);
            active_next = !(ack_inc >= total_ext);
        end
        if (cmd.run_init)
        begin
            count_next  = '0;
            cursor_next = base_reg;
        end
        if (cmd.emit_new)
        begin
            valid_next = 1'b1;
            kind_next  = KIND_NEW;
            seq_next   = send_reg[SEQ_W-1:0];
            last_next  = sts.send_last;
            send_next  = CNT_W'(send_inc);
            count_next = count_reg + RES_CNT_W'(1);
        end
        if (cmd.emit_resend)
        begin
            valid_next  = 1'b1;
            kind_next   = KIND_RESEND;
            seq_next    = cursor_reg[SEQ_W-1:0];
            last_next   = sts.resend_last;
            cursor_next = CNT_W'(cursor_inc);
            count_next  = count_reg + RES_CNT_W'(1);
        end
        if (cmd.emit_done)
        begin
            valid_next = 1'b1;
            kind_next  = KIND_DONE;
            seq_next   = '0;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            base_reg   <= '0;
            send_reg   <= '0;
            total_reg  <= '0;
            active_reg <= 1'b0;
            cursor_reg <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            base_reg   <= base_next;
            send_reg   <= send_next;
            total_reg  <= total_next;
            active_reg <= active_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_type_reg  <= req_type;
            ev_count_reg <= frame_total;
            ev_ack_reg   <= ack_seq;
            ev_flag_reg  <= is_ack;
        end
        kind_reg <= kind_next;
        seq_reg  <= seq_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_seq   = seq_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

/* hdl/go_back_n_sender_window_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Window control of a go-back-n sender: turns start, ack and timeout events
// into frame send, frame resend and completion beats.
//
//   channel  dir  payload
//   req      in   req_type, frame_total, ack_seq, is_ack
//   res      out  result_kind, frame_seq, last_of_run
//   cfg      in   win_size
//
// an event is captured, then executed, then emits its result beats one after another
// while the result register is free; an accepted ack that frees no frame emits none
// the single result register paces emission
// the next event is taken once the last beat of a run is in the result register
// res stalls hold the result register and pause emission
// reset puts the window size to 4 and the sender idle; no clearing pass
// ----------------------------------------------------------------------------
module go_back_n_sender_window_top
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW      = 16,
    parameter int MAX_FRAME_COUNT = 128
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gbn_req_if.sink    req,
    gbn_res_if.source  res,
    gbn_cfg_if.sink    cfg
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbn_datapath #(
        .MAX_WINDOW      (MAX_WINDOW),
        .MAX_FRAME_COUNT (MAX_FRAME_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req.req_type),
        .frame_total (req.frame_total),
        .ack_seq     (req.ack_seq),
        .is_ack      (req.is_ack),
        .cfg_write   (cfg.valid),
        .cfg_window  (cfg.win_size),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .out_kind    (res.result_kind),
        .out_seq     (res.frame_seq),
        .out_last    (res.last_of_run)
    );

endmodule
`default_nettype wire

/* hdl/gbn_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the go-back-n sender window block.
// ----------------------------------------------------------------------------
module gbn_checker
    import gbn_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [KIND_W-1:0] result_kind,
    input wire logic [SEQ_W-1:0]  frame_seq,
    input wire logic              last_of_run
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(result_kind) && $stable(frame_seq) && $stable(last_of_run))
        else $error("result payload changed while stalled");

    // one event at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("event taken while previous event in progress");

    // completion closes the run
    a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_DONE) |-> last_of_run && (frame_seq == '0))
        else $error("malformed completion beat");

    // mid-run beat means the run is still going
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("event taken before run finished");

endmodule

bind go_back_n_sender_window_top gbn_checker u_gbn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .result_kind (res.result_kind),
    .frame_seq   (res.frame_seq),
    .last_of_run (res.last_of_run)
);
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the go-back-n sender window block. A short table
// of directed events (idle events, empty and oversized messages, stale and
// out-of-range acks, window extremes, window shrunk mid-message) is followed
// by randomized message sequences. Every accepted event runs through a local
// window predictor; each result beat is checked in order against it.
// ----------------------------------------------------------------------------
module tb;
    import gbn_pkg::*;

    localparam int WIN_MAX     = 16;
    localparam int FRAMES_MAX  = 128;
    localparam int RAND_EVENTS = 400;
    localparam int PHASE_LEN   = 40;
    localparam int SETTLE      = 40;
    localparam int LIMIT_NS    = 5_000_000;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef enum logic { ROW_EVENT, ROW_CONFIG } row_op_t;
    typedef enum logic [1:0] { RDY_ALWAYS, RDY_MOSTLY, RDY_COIN, RDY_SPARSE } ready_mode_t;

    typedef struct {
        result_kind_t     kind;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } frame_beat_t;

    typedef struct {
        row_op_t          op;
        logic [REQ_W-1:0] req_type;
        logic [CNT_W-1:0] frame_total;
        logic [SEQ_W-1:0] ack_seq;
        logic             is_ack;
        logic [CFG_W-1:0] window;
        logic             typed;
        result_kind_t     kind;
        logic [SEQ_W-1:0] seq;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gbn_req_if req_ch ();
    gbn_res_if res_ch ();
    gbn_cfg_if cfg_ch ();

    go_back_n_sender_window_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // window predictor state
    logic [CFG_W-1:0] win_cfg;
    logic [CNT_W-1:0] win_base;
    logic [CNT_W-1:0] win_next;
    logic [CNT_W-1:0] msg_frames;
    logic             msg_live;
    logic             pr_effect;

    frame_beat_t frames_due[$];
    frame_beat_t run_q[$];
    dir_row_t    dir_rows[$];

    int mismatches = 0;
    int burst_left = 0;

    ready_mode_t stall_mode = RDY_ALWAYS;
    int          stall_left = 0;
    logic [7:0]  stall_tick = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("** go_back_n_sender_window_top: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
        begin
            $display("%0t ns mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic void queue_beat(result_kind_t kind, int seq);
        frame_beat_t b;
        if (run_q.size() < RESULT_LIMIT)
        begin
            b.kind = kind;
            b.seq  = SEQ_W'(seq);
            b.last = 1'b0;
            run_q.push_back(b);
        end
    endfunction

    function automatic void fill_window(int w);
        while (win_next < msg_frames && int'(win_next) < int'(win_base) + w &&
               run_q.size() < RESULT_LIMIT)
        begin
            queue_beat(KIND_NEW, win_next);
            win_next++;
        end
    endfunction

    function automatic void predict_event(logic [REQ_W-1:0] rt, logic [CNT_W-1:0] cnt,
                                          logic [SEQ_W-1:0] ack, logic flag);
        int          w;
        int          i;
        frame_beat_t b;
        run_q.delete();
        pr_effect = 1'b0;
        w = (win_cfg == 0) ? 1 : ((int'(win_cfg) > WIN_MAX) ? WIN_MAX : int'(win_cfg));
        case (rt)
            REQ_START:
            begin
                pr_effect  = 1'b1;
                msg_frames = (int'(cnt) > FRAMES_MAX) ? CNT_W'(FRAMES_MAX) : cnt;
                win_base   = '0;
                win_next   = '0;
                if (msg_frames == 0)
                begin
                    msg_live = 1'b0;
                    queue_beat(KIND_DONE, 0);
                end
                else
                begin
                    msg_live = 1'b1;
                    fill_window(w);
                end
            end
            REQ_ACK:
            begin
                if (msg_live && flag && {1'b0, ack} >= win_base && {1'b0, ack} < win_next)
                begin
                    pr_effect = 1'b1;
                    win_base  = {1'b0, ack} + 8'd1;
                    if (win_base >= msg_frames)
                    begin
                        msg_live = 1'b0;
                        queue_beat(KIND_DONE, 0);
                    end
                    else
                    begin
                        fill_window(w);
                    end
                end
            end
            REQ_TIMEOUT:
            begin
                if (msg_live)
                begin
                    pr_effect = 1'b1;
                    for (i = win_base; i < int'(win_next); i++)
                    begin
                        queue_beat(KIND_RESEND, i);
                    end
                end
            end
            default: ;
        endcase
        if (run_q.size() > 0)
        begin
            b = run_q[run_q.size() - 1];
            b.last = 1'b1;
            run_q[run_q.size() - 1] = b;
        end
    endfunction

    function automatic dir_row_t ev_row(logic [REQ_W-1:0] rt, logic [CNT_W-1:0] cnt,
                                        logic [SEQ_W-1:0] ack, logic flag);
        dir_row_t r;
        r.op          = ROW_EVENT;
        r.req_type    = rt;
        r.frame_total = cnt;
        r.ack_seq     = ack;
        r.is_ack      = flag;
        r.window      = '0;
        r.typed       = 1'b0;
        r.kind        = KIND_NEW;
        r.seq         = '0;
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic [REQ_W-1:0] rt, logic [CNT_W-1:0] cnt,
                                           logic [SEQ_W-1:0] ack, logic flag,
                                           result_kind_t kind, logic [SEQ_W-1:0] seq);
        dir_row_t r;
        r       = ev_row(rt, cnt, ack, flag);
        r.typed = 1'b1;
        r.kind  = kind;
        r.seq   = seq;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_W-1:0] w);
        dir_row_t r;
        r        = ev_row(REQ_START, '0, '0, 1'b0);
        r.op     = ROW_CONFIG;
        r.window = w;
        return r;
    endfunction

    // lower valid, wait for all outstanding beats, then let the block settle
    task automatic drain_results(input int extra);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        drain_results(SETTLE);
        @(negedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.win_size <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        win_cfg = w;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_event(input logic [REQ_W-1:0] rt, input logic [CNT_W-1:0] cnt,
                              input logic [SEQ_W-1:0] ack, input logic flag,
                              input logic typed, input result_kind_t kind,
                              input logic [SEQ_W-1:0] seq);
        int          gap;
        frame_beat_t b;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.frame_total <= cnt;
        req_ch.ack_seq     <= ack;
        req_ch.is_ack      <= flag;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predict_event(rt, cnt, ack, flag);
        if (typed)
        begin
            b.kind = kind;
            b.seq  = seq;
            b.last = 1'b1;
            frames_due.push_back(b);
        end
        else
        begin
            foreach (run_q[i])
            begin
                frames_due.push_back(run_q[i]);
            end
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = ready_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            RDY_ALWAYS: res_ch.ready <= 1'b1;
            RDY_MOSTLY: res_ch.ready <= (stall_tick[1:0] != 2'b11);
            RDY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
            default:    res_ch.ready <= (stall_tick[2:0] == 3'b000);
        endcase
    end

    always @(posedge clk)
    begin : res_check
        frame_beat_t due;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (frames_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat kind %0d seq %0d last %0d",
                                res_ch.result_kind, res_ch.frame_seq, res_ch.last_of_run));
            end
            else
            begin
                due = frames_due.pop_front();
                if (res_ch.result_kind !== due.kind)
                begin
                    report_mismatch($sformatf("result_kind %0d, want %0d",
                                    res_ch.result_kind, due.kind));
                end
                if (res_ch.frame_seq !== due.seq)
                begin
                    report_mismatch($sformatf("frame_seq %0d, want %0d",
                                    res_ch.frame_seq, due.seq));
                end
                if (res_ch.last_of_run !== due.last)
                begin
                    report_mismatch($sformatf("last_of_run %0d, want %0d",
                                    res_ch.last_of_run, due.last));
                end
            end
        end
    end

    initial
    begin : stimulus
        int               counted;
        int               phase_left;
        int               r;
        int               k;
        logic [REQ_W-1:0] rt;
        logic [CNT_W-1:0] cnt;
        logic [SEQ_W-1:0] ack;
        logic             flag;

        req_ch.valid       = 1'b0;
        req_ch.req_type    = '0;
        req_ch.frame_total = '0;
        req_ch.ack_seq     = '0;
        req_ch.is_ack      = 1'b0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.win_size    = '0;

        win_cfg    = WINDOW_RESET;
        win_base   = '0;
        win_next   = '0;
        msg_frames = '0;
        msg_live   = 1'b0;
        pr_effect  = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset window of four
        dir_rows.push_back(ev_row(REQ_TIMEOUT, 8'd0, 7'd0, 1'b0));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd0, 1'b1));
        dir_rows.push_back(typed_row(REQ_START, 8'd0, 7'd0, 1'b0, KIND_DONE, 7'd0));
        dir_rows.push_back(typed_row(REQ_START, 8'd1, 7'd0, 1'b0, KIND_NEW, 7'd0));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd0, 1'b0));
        dir_rows.push_back(ev_row(REQ_UNKNOWN, 8'd255, 7'd127, 1'b1));
        dir_rows.push_back(typed_row(REQ_ACK, 8'd0, 7'd0, 1'b1, KIND_DONE, 7'd0));
        dir_rows.push_back(ev_row(REQ_START, 8'd255, 7'd0, 1'b0));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd5, 1'b1));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd1, 1'b1));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd0, 1'b1));
        dir_rows.push_back(ev_row(REQ_TIMEOUT, 8'd0, 7'd0, 1'b0));
        dir_rows.push_back(ev_row(REQ_START, 8'd10, 7'd0, 1'b0));
        // widest window, full message
        dir_rows.push_back(cfg_row(5'd16));
        dir_rows.push_back(ev_row(REQ_START, 8'd128, 7'd0, 1'b0));
        dir_rows.push_back(ev_row(REQ_TIMEOUT, 8'd0, 7'd0, 1'b0));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd127, 1'b1));
        // shrink with frames outstanding
        dir_rows.push_back(cfg_row(5'd2));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd3, 1'b1));
        dir_rows.push_back(ev_row(REQ_TIMEOUT, 8'd0, 7'd0, 1'b0));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd15, 1'b1));
        dir_rows.push_back(cfg_row(5'd31));
        dir_rows.push_back(ev_row(REQ_ACK, 8'd0, 7'd17, 1'b1));
        // zero window behaves as one
        dir_rows.push_back(cfg_row(5'd0));
        dir_rows.push_back(typed_row(REQ_START, 8'd3, 7'd0, 1'b0, KIND_NEW, 7'd0));
        dir_rows.push_back(typed_row(REQ_ACK, 8'd0, 7'd0, 1'b1, KIND_NEW, 7'd1));
        dir_rows.push_back(typed_row(REQ_ACK, 8'd0, 7'd1, 1'b1, KIND_NEW, 7'd2));
        dir_rows.push_back(typed_row(REQ_ACK, 8'd0, 7'd2, 1'b1, KIND_DONE, 7'd0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_CONFIG)
            begin
                write_window(dir_rows[i].window);
            end
            else
            begin
                send_event(dir_rows[i].req_type, dir_rows[i].frame_total,
                           dir_rows[i].ack_seq, dir_rows[i].is_ack,
                           dir_rows[i].typed, dir_rows[i].kind, dir_rows[i].seq);
            end
        end

        counted    = 0;
        phase_left = 0;
        while (counted < RAND_EVENTS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       write_window(5'd0);
                    1:       write_window(5'd1);
                    2:       write_window(5'd16);
                    3:       write_window(5'd31);
                    default: write_window(CFG_W'($urandom_range(0, 31)));
                endcase
                phase_left = PHASE_LEN;
            end
            rt   = REQ_START;
            cnt  = CNT_W'($urandom_range(0, 255));
            ack  = SEQ_W'($urandom_range(0, 127));
            flag = 1'($urandom_range(0, 1));
            r    = $urandom_range(0, 99);
            if (!msg_live && r < 80)
            begin
                r = 0;
            end
            if (r < 5)
            begin
                k = $urandom_range(0, 19);
                if (k == 0)
                    cnt = CNT_W'($urandom_range(129, 255));
                else if (k == 1)
                    cnt = CNT_W'(FRAMES_MAX);
                else if (k == 2)
                    cnt = '0;
                else
                    cnt = CNT_W'($urandom_range(1, 24));
            end
            else if (r < 68 && msg_live)
            begin
                rt   = REQ_ACK;
                ack  = SEQ_W'($urandom_range(win_base, win_next - 1));
                flag = 1'b1;
            end
            else if (r < 80)
            begin
                rt = REQ_TIMEOUT;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        rt = REQ_ACK;
                        flag = 1'b1;
                        if (win_base > 0)
                            ack = SEQ_W'($urandom_range(0, win_base - 1));
                    end
                    1:
                    begin
                        rt = REQ_ACK;
                        flag = 1'b1;
                        if (win_next <= 127)
                            ack = SEQ_W'($urandom_range(win_next, 127));
                    end
                    2:
                    begin
                        rt = REQ_ACK;
                        flag = 1'b0;
                        if (msg_live)
                            ack = SEQ_W'($urandom_range(win_base, win_next - 1));
                    end
                    3:       rt = REQ_UNKNOWN;
                    default: rt = REQ_W'($urandom_range(0, 3));
                endcase
            end
            send_event(rt, cnt, ack, flag, 1'b0, KIND_NEW, '0);
            counted++;
            if (pr_effect)
            begin
                phase_left--;
            end
        end

        drain_results(SETTLE);
        if (mismatches == 0)
        begin
            $display("** go_back_n_sender_window_top: PASSED **");
        end
        else
        begin
            $display("** go_back_n_sender_window_top: FAILED **");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/gbn_pkg.sv
hdl/gbn_req_if.sv
hdl/gbn_res_if.sv
hdl/gbn_cfg_if.sv
hdl/gbn_ctrl.sv
hdl/gbn_datapath.sv
hdl/go_back_n_sender_window_top.sv
hdl/gbn_checker.sv
test/tb.sv
